// ----- rtl/uvs_pkg.sv -----
package uvs_pkg;

	// fixed field widths
	localparam int IDX_W      = 8;
	localparam int CFG_W      = 9;
	localparam int CFG_ADDR_W = 1;
	localparam int COORD_W    = 16;
	localparam int TEX_W      = 16;
	localparam int PHASE_W    = 16;

	// grid index fed to the phase units: up to twice a sector index plus two
	localparam int N_W = 10;
	// unwrapped phase, before the turn is taken modulo
	localparam int G_W = 25;
	// quotient of one turn by twice a count
	localparam int QUO_W = 16;

	localparam int MAX_SECTORS_DEF = 256;
	localparam int MAX_STACKS_DEF  = 256;

	localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_COUNT = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STACK_COUNT  = 1'd1;

	localparam logic [CFG_W-1:0] SECTOR_COUNT_RST = 9'd32;
	localparam logic [CFG_W-1:0] STACK_COUNT_RST  = 9'd16;

	localparam logic [16:0] ONE_TURN = 17'h10000;
	localparam logic [14:0] QUARTER  = 15'd16384;
	localparam logic [15:0] ONE_Q14  = 16'd16384;
	localparam logic [15:0] ONE_Q15  = 16'd32768;

	// quarter-wave sine polynomial
	localparam logic [12:0] SIN_C1 = 13'd4640;
	localparam logic [15:0] SIN_C2 = 16'd42048;
	localparam logic [16:0] SIN_C3 = 17'd102944;

	localparam logic [2:0] LAST_VTX = 3'd5;

	// stack and sector offsets of vertices p1,p2,p3,p3,p2,p4, bit n for vertex n
	localparam logic [5:0] DK_MASK = 6'b110010;
	localparam logic [5:0] DM_MASK = 6'b101100;

	localparam int PHASE_LAT = 3;
	localparam int SINE_LAT  = 5;

	typedef struct packed {
		logic [IDX_W-1:0] stack;
		logic [IDX_W-1:0] sector;
	} cell_t;

endpackage

// ----- rtl/uvs_recip.sv -----
module uvs_recip #(
	parameter int CNT_W = 9,
	parameter int DIV_W = 10,
	parameter int RCP_W = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [CNT_W-1:0]            sec_cnt,
	input  logic [CNT_W-1:0]            stk_cnt,
	output logic                        busy,
	output logic [uvs_pkg::QUO_W-1:0]   sec_quo,
	output logic [DIV_W-1:0]            sec_rem,
	output logic [RCP_W-1:0]            sec_rcp,
	output logic [uvs_pkg::QUO_W-1:0]   stk_quo,
	output logic [DIV_W-1:0]            stk_rem,
	output logic [RCP_W-1:0]            stk_rcp
);
	import uvs_pkg::*;

	localparam int DVD_W = RCP_W + 1;
	localparam int BIT_W = $clog2(DVD_W);

	typedef enum logic [1:0] {ST_LOAD, ST_STEP, ST_IDLE} state_t;
	typedef enum logic [1:0] {JOB_SEC_QR, JOB_SEC_RCP, JOB_STK_QR, JOB_STK_RCP} job_t;

	state_t             state_q;
	job_t               job_q;
	logic [BIT_W-1:0]   bit_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DVD_W-1:0]   quo_q;
	logic [DIV_W-1:0]   rem_q;
	logic [QUO_W-1:0]   sec_quo_q, stk_quo_q;
	logic [DIV_W-1:0]   sec_rem_q, stk_rem_q;
	logic [RCP_W-1:0]   sec_rcp_q, stk_rcp_q;

	logic               is_sec, is_qr, fits;
	logic [DIV_W-1:0]   dsr, rem_nxt;
	logic [DIV_W:0]     shifted;
	logic [DVD_W-1:0]   quo_nxt, dvd_init;

	always_comb begin
		is_sec   = (job_q == JOB_SEC_QR) || (job_q == JOB_SEC_RCP);
		is_qr    = (job_q == JOB_SEC_QR) || (job_q == JOB_STK_QR);
		dsr      = is_sec ? {sec_cnt, 1'b0} : {stk_cnt, 1'b0};
		// reciprocal is rounded up: (2^K + d - 1) / d
		dvd_init = is_qr ? DVD_W'(ONE_TURN)
		                 : ({1'b1, {RCP_W{1'b0}}} + DVD_W'(dsr) - DVD_W'(1));
		shifted  = {rem_q, dvd_q[DVD_W-1]};
		fits     = shifted >= {1'b0, dsr};
		rem_nxt  = fits ? DIV_W'(shifted - {1'b0, dsr}) : shifted[DIV_W-1:0];
		quo_nxt  = {quo_q[DVD_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			job_q     <= JOB_SEC_QR;
			bit_q     <= '0;
			dvd_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			sec_quo_q <= '0;
			sec_rem_q <= '0;
			sec_rcp_q <= '0;
			stk_quo_q <= '0;
			stk_rem_q <= '0;
			stk_rcp_q <= '0;
		end else if (restart) begin
			state_q <= ST_LOAD;
			job_q   <= JOB_SEC_QR;
		end else begin
			case (state_q)
				ST_LOAD: begin
					dvd_q   <= dvd_init;
					rem_q   <= '0;
					quo_q   <= '0;
					bit_q   <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					bit_q <= bit_q + 1'b1;
					if (bit_q == BIT_W'(DVD_W - 1)) begin
						case (job_q)
							JOB_SEC_QR: begin
								sec_quo_q <= quo_nxt[QUO_W-1:0];
								sec_rem_q <= rem_nxt;
							end
							JOB_SEC_RCP: sec_rcp_q <= quo_nxt[RCP_W-1:0];
							JOB_STK_QR: begin
								stk_quo_q <= quo_nxt[QUO_W-1:0];
								stk_rem_q <= rem_nxt;
							end
							default: stk_rcp_q <= quo_nxt[RCP_W-1:0];
						endcase
						if (job_q == JOB_STK_RCP) begin
							state_q <= ST_IDLE;
						end else begin
							job_q   <= job_t'(job_q + 1'b1);
							state_q <= ST_LOAD;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign sec_quo = sec_quo_q;
	assign sec_rem = sec_rem_q;
	assign sec_rcp = sec_rcp_q;
	assign stk_quo = stk_quo_q;
	assign stk_rem = stk_rem_q;
	assign stk_rcp = stk_rcp_q;

endmodule

// ----- rtl/uvs_phase.sv -----
module uvs_phase #(
	parameter int CNT_W = 9,
	parameter int DIV_W = 10,
	parameter int RCP_W = 30
) (
	input  logic                       clk,
	input  logic [uvs_pkg::N_W-1:0]    idx,
	input  logic [CNT_W-1:0]           cnt,
	input  logic [uvs_pkg::QUO_W-1:0]  quo,
	input  logic [DIV_W-1:0]           rem,
	input  logic [RCP_W-1:0]           rcp,
	output logic [uvs_pkg::G_W-1:0]    g
);
	import uvs_pkg::*;

	localparam int X_W = N_W + DIV_W;
	localparam int P_W = X_W + RCP_W;

	logic [G_W-1:0] nq_s1, nq_s2, g_s3;
	logic [X_W-1:0] x_s1;
	logic [P_W-1:0] xm_s2;

	// floor((idx*2^16 + cnt) / 2cnt) = idx*quo + floor((idx*rem + cnt) / 2cnt)
	always_ff @(posedge clk) begin
		nq_s1 <= G_W'(idx) * G_W'(quo);
		x_s1  <= X_W'(idx) * X_W'(rem) + X_W'(cnt);
		nq_s2 <= nq_s1;
		xm_s2 <= P_W'(x_s1) * P_W'(rcp);
		g_s3  <= nq_s2 + G_W'(xm_s2[RCP_W +: N_W]);
	end

	assign g = g_s3;

endmodule

// ----- rtl/uvs_sine.sv -----
module uvs_sine (
	input  logic                         clk,
	input  logic [uvs_pkg::PHASE_W-1:0]  phase,
	output logic [uvs_pkg::COORD_W-1:0]  sine
);
	import uvs_pkg::*;

	logic [14:0] ff;
	logic [16:0] z;
	logic [33:0] zz;
	logic [29:0] p2;
	logic [32:0] p3;
	logic [33:0] p4;
	logic [17:0] rr;
	logic [15:0] mag;

	logic [16:0] z_s1, z2_s1, z_s2, z2_s2, z_s3, r_s4;
	logic [12:0] t_s2;
	logic [15:0] v_s3, sine_s5;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;

	always_comb begin
		// odd quadrants run the quarter wave backwards
		ff  = phase[14] ? 15'(QUARTER - 15'(phase[13:0])) : 15'(phase[13:0]);
		z   = {ff, 2'b00};
		zz  = 34'(z) * 34'(z);
		p2  = 30'(SIN_C1) * 30'(z2_s1);
		p3  = 33'(SIN_C2 - 16'(t_s2)) * 33'(z2_s2);
		p4  = 34'(SIN_C3 - 17'(v_s3)) * 34'(z_s3);
		rr  = 18'(r_s4) + 18'd2;
		mag = (rr[17:2] > ONE_Q14) ? ONE_Q14 : rr[17:2];
	end

	always_ff @(posedge clk) begin
		z_s1    <= z;
		z2_s1   <= zz[32:16];
		neg_s1  <= phase[15];
		t_s2    <= p2[28:16];
		z2_s2   <= z2_s1;
		z_s2    <= z_s1;
		neg_s2  <= neg_s1;
		v_s3    <= p3[31:16];
		z_s3    <= z_s2;
		neg_s3  <= neg_s2;
		r_s4    <= p4[32:16];
		neg_s4  <= neg_s3;
		sine_s5 <= neg_s4 ? 16'(16'd0 - mag) : mag;
	end

	assign sine = sine_s5;

endmodule

// ----- rtl/uvs_back.sv -----
module uvs_back #(
	parameter int CNT_W = 9,
	parameter int DIV_W = 10,
	parameter int RCP_W = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cell_valid,
	input  uvs_pkg::cell_t               cell_in,
	output logic                         pop,
	input  logic [CNT_W-1:0]             sec_cnt,
	input  logic [CNT_W-1:0]             stk_cnt,
	input  logic [uvs_pkg::QUO_W-1:0]    sec_quo,
	input  logic [DIV_W-1:0]             sec_rem,
	input  logic [RCP_W-1:0]             sec_rcp,
	input  logic [uvs_pkg::QUO_W-1:0]    stk_quo,
	input  logic [DIV_W-1:0]             stk_rem,
	input  logic [RCP_W-1:0]             stk_rcp,
	output logic                         vtx_valid,
	output logic                         vtx_last,
	output logic [uvs_pkg::COORD_W-1:0]  vx,
	output logic [uvs_pkg::COORD_W-1:0]  vy,
	output logic [uvs_pkg::COORD_W-1:0]  vz,
	output logic [uvs_pkg::TEX_W-1:0]    tu,
	output logic [uvs_pkg::TEX_W-1:0]    tv
);
	import uvs_pkg::*;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} meta_t;

	function automatic logic [COORD_W-1:0] mul_q14(input logic [COORD_W-1:0] a,
	                                                input logic [COORD_W-1:0] b);
		logic [14:0]        ma, mb;
		logic [29:0]        p;
		logic [COORD_W-1:0] m;
		ma = a[15] ? 15'(16'd0 - a) : a[14:0];
		mb = b[15] ? 15'(16'd0 - b) : b[14:0];
		p  = 30'(ma) * 30'(mb) + 30'd8192;
		m  = p[29:14];
		return (a[15] ^ b[15]) ? COORD_W'(16'd0 - m) : m;
	endfunction

	function automatic logic [TEX_W-1:0] tex_sat(input logic [G_W-1:0] g);
		return (g > G_W'(ONE_Q15)) ? ONE_Q15 : g[TEX_W-1:0];
	endfunction

	logic               active_q;
	logic [2:0]         vtx_q;
	cell_t              cell_q;
	logic [8:0]         k, m;
	logic [N_W-1:0]     n_phi, n_tu, n_th;
	logic [G_W-1:0]     g_phi, g_tu, g_th;
	logic [COORD_W-1:0] sin_phi, cos_phi, sin_th, cos_th;
	logic [COORD_W-1:0] x_q, y_q, z_q;
	ctl_t               ctl_q [PHASE_LAT];
	meta_t              meta_q [SINE_LAT+1];

	// sequencer: one vertex a cycle, next cell taken on the last vertex
	assign pop = cell_valid && (!active_q || (vtx_q == LAST_VTX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			vtx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			vtx_q    <= '0;
		end else if (active_q) begin
			if (vtx_q == LAST_VTX) begin
				active_q <= 1'b0;
			end else begin
				vtx_q <= vtx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cell_q <= cell_in;
		end
	end

	always_comb begin
		k     = 9'(cell_q.stack) + 9'(DK_MASK[vtx_q]);
		m     = 9'(cell_q.sector) + 9'(DM_MASK[vtx_q]);
		n_phi = N_W'(k);
		n_tu  = N_W'(m);
		n_th  = {n_tu[N_W-2:0], 1'b0};
	end

	uvs_phase #(.CNT_W(CNT_W), .DIV_W(DIV_W), .RCP_W(RCP_W)) u_phase_phi (
		.clk(clk), .idx(n_phi), .cnt(stk_cnt),
		.quo(stk_quo), .rem(stk_rem), .rcp(stk_rcp), .g(g_phi)
	);

	uvs_phase #(.CNT_W(CNT_W), .DIV_W(DIV_W), .RCP_W(RCP_W)) u_phase_tu (
		.clk(clk), .idx(n_tu), .cnt(sec_cnt),
		.quo(sec_quo), .rem(sec_rem), .rcp(sec_rcp), .g(g_tu)
	);

	uvs_phase #(.CNT_W(CNT_W), .DIV_W(DIV_W), .RCP_W(RCP_W)) u_phase_th (
		.clk(clk), .idx(n_th), .cnt(sec_cnt),
		.quo(sec_quo), .rem(sec_rem), .rcp(sec_rcp), .g(g_th)
	);

	uvs_sine u_sin_phi (.clk(clk), .phase(g_phi[PHASE_W-1:0]), .sine(sin_phi));
	uvs_sine u_cos_phi (.clk(clk), .phase(g_phi[PHASE_W-1:0] + 16'd16384), .sine(cos_phi));
	uvs_sine u_sin_th  (.clk(clk), .phase(g_th[PHASE_W-1:0]), .sine(sin_th));
	uvs_sine u_cos_th  (.clk(clk), .phase(g_th[PHASE_W-1:0] + 16'd16384), .sine(cos_th));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASE_LAT; i++) begin
				ctl_q[i] <= '0;
			end
			for (int i = 0; i <= SINE_LAT; i++) begin
				meta_q[i] <= '0;
			end
		end else begin
			ctl_q[0] <= '{valid: active_q, last: active_q && (vtx_q == LAST_VTX)};
			for (int i = 1; i < PHASE_LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
			meta_q[0] <= '{valid: ctl_q[PHASE_LAT-1].valid, last: ctl_q[PHASE_LAT-1].last,
			               tex_u: tex_sat(g_tu), tex_v: tex_sat(g_phi)};
			for (int i = 1; i <= SINE_LAT; i++) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q <= mul_q14(sin_phi, cos_th);
		y_q <= cos_phi;
		z_q <= mul_q14(sin_phi, sin_th);
	end

	assign vtx_valid = meta_q[SINE_LAT].valid;
	assign vtx_last  = meta_q[SINE_LAT].last;
	assign tu        = meta_q[SINE_LAT].tex_u;
	assign tv        = meta_q[SINE_LAT].tex_v;
	assign vx        = x_q;
	assign vy        = y_q;
	assign vz        = z_q;

endmodule

// ----- rtl/uv_sphere_vertex_generator.sv -----
// uv sphere cell tessellator
// command channel: a cell (stack_index, sector_index) is taken at a rising edge with
// start high and busy low. every cell yields six vertex words, p1,p2,p3,p3,p2,p4, on
// consecutive cycles, each marked by vtx_valid for one cycle; last_of_cell marks the
// sixth. the receiver has no way to stall, so words are never held.
// a taken cell passes the command queue, the cell register of the sequencer, the
// phase units, the sine units and the output register before its words show.
// throughput: one vertex per cycle while cells are queued; the vertex sequencer
// of the back end sets this. a two-word command queue sits between the accepting
// front and the sequencer, so start may be given back to back and busy rises when
// that queue is full or while the divider runs.
// configuration: cfg_we writes sector_count (index 0) or stack_count (index 1). each
// write, and the release of reset, starts a serial divider that works out the
// quotient and reciprocal of twice each count, one bit per cycle; busy stays high
// while it runs.
// reset: counts return to 32 sectors and 16 stacks, queue and pipeline empty.
module uv_sphere_vertex_generator #(
	parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
	parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [uvs_pkg::IDX_W-1:0]          stack_index,
	input  logic [uvs_pkg::IDX_W-1:0]          sector_index,
	input  logic                               cfg_we,
	input  logic [uvs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [uvs_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                               vtx_valid,
	output logic signed [uvs_pkg::COORD_W-1:0] pos_x,
	output logic signed [uvs_pkg::COORD_W-1:0] pos_y,
	output logic signed [uvs_pkg::COORD_W-1:0] pos_z,
	output logic signed [uvs_pkg::COORD_W-1:0] norm_x,
	output logic signed [uvs_pkg::COORD_W-1:0] norm_y,
	output logic signed [uvs_pkg::COORD_W-1:0] norm_z,
	output logic [uvs_pkg::TEX_W-1:0]          tex_u,
	output logic [uvs_pkg::TEX_W-1:0]          tex_v,
	output logic                               last_of_cell
);
	import uvs_pkg::*;

	localparam int MAX_CNT    = (MAX_SECTORS > MAX_STACKS) ? MAX_SECTORS : MAX_STACKS;
	localparam int CNT_W      = $clog2(MAX_CNT + 1);
	// twice a count
	localparam int DIV_W      = CNT_W + 1;
	// reciprocal precision: exact floor for any fraction numerator below 2^(N_W+DIV_W)
	localparam int RCP_W      = N_W + 2 * DIV_W;
	localparam int FIFO_DEPTH = 2;

	logic [CFG_W-1:0]   sector_count_q, stack_count_q;
	logic [CNT_W-1:0]   sec_cnt, stk_cnt;

	cell_t              fifo_q [FIFO_DEPTH];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push, pop, rcp_busy;

	logic [QUO_W-1:0]   sec_quo, stk_quo;
	logic [DIV_W-1:0]   sec_rem, stk_rem;
	logic [RCP_W-1:0]   sec_rcp, stk_rcp;
	logic [COORD_W-1:0] vx, vy, vz;

	// ---- configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= SECTOR_COUNT_RST;
			stack_count_q  <= STACK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SECTOR_COUNT: sector_count_q <= cfg_wdata;
				REG_STACK_COUNT:  stack_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the limit acts as the limit
	always_comb begin
		if (sector_count_q == '0) begin
			sec_cnt = CNT_W'(1);
		end else if (32'(sector_count_q) > MAX_SECTORS) begin
			sec_cnt = CNT_W'(MAX_SECTORS);
		end else begin
			sec_cnt = CNT_W'(sector_count_q);
		end
		if (stack_count_q == '0) begin
			stk_cnt = CNT_W'(1);
		end else if (32'(stack_count_q) > MAX_STACKS) begin
			stk_cnt = CNT_W'(MAX_STACKS);
		end else begin
			stk_cnt = CNT_W'(stack_count_q);
		end
	end

	// ---- divider constants per count, rerun after every write
	uvs_recip #(.CNT_W(CNT_W), .DIV_W(DIV_W), .RCP_W(RCP_W)) u_recip (
		.clk(clk), .arst_n(arst_n), .restart(cfg_we),
		.sec_cnt(sec_cnt), .stk_cnt(stk_cnt), .busy(rcp_busy),
		.sec_quo(sec_quo), .sec_rem(sec_rem), .sec_rcp(sec_rcp),
		.stk_quo(stk_quo), .stk_rem(stk_rem), .stk_rcp(stk_rcp)
	);

	// ---- front: command queue
	assign busy = rcp_busy || (cnt_q == 2'(FIFO_DEPTH));
	assign push = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{stack: stack_index, sector: sector_index};
		end
	end

	// ---- back: vertex sequencer and math pipeline
	uvs_back #(.CNT_W(CNT_W), .DIV_W(DIV_W), .RCP_W(RCP_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cnt_q != 2'd0), .cell_in(fifo_q[rd_ptr_q]), .pop(pop),
		.sec_cnt(sec_cnt), .stk_cnt(stk_cnt),
		.sec_quo(sec_quo), .sec_rem(sec_rem), .sec_rcp(sec_rcp),
		.stk_quo(stk_quo), .stk_rem(stk_rem), .stk_rcp(stk_rcp),
		.vtx_valid(vtx_valid), .vtx_last(last_of_cell),
		.vx(vx), .vy(vy), .vz(vz), .tu(tex_u), .tv(tex_v)
	);

	// normal of a unit sphere is the position itself
	assign pos_x  = vx;
	assign pos_y  = vy;
	assign pos_z  = vz;
	assign norm_x = vx;
	assign norm_y = vy;
	assign norm_z = vz;

`ifndef SYNTHESIS
	a_no_push_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		rcp_busy |-> !push) else $error("cell taken while divider constants are stale");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("command queue popped while empty");
	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_cell |-> vtx_valid) else $error("last_of_cell without a word");
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && last_of_cell |=> !last_of_cell) else $error("two last words in a row");
`endif

endmodule
